// ===== rtl/sine_voice_with_linear_envelope_assert.svh =====
// assertion macros for the sine voice
`ifndef SINE_VOICE_WITH_LINEAR_ENVELOPE_ASSERT_SVH
`define SINE_VOICE_WITH_LINEAR_ENVELOPE_ASSERT_SVH

`ifndef SYNTH
`define SVLE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svle assertion failed");
`define SVLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svle assertion failed");
`else
`define SVLE_ASSERT_SAME(label, ante, cons)
`define SVLE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/svle_pkg.sv =====
package svle_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int SAMPLE_BITS     = 24;

    localparam int QUARTER_LEN = 1 << SINE_TABLE_BITS;
    localparam int PHASE_W     = 32;
    localparam int LEVEL_W     = 15;
    localparam int VOL_W       = 16;
    localparam int SINE_W      = 15;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CMD_W       = 2;

    localparam int MUL_A_W   = 2 * SINE_W;
    localparam int MUL_B_W   = VOL_W;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int RND_SHIFT = PROD_W - SAMPLE_BITS;
    localparam int MAG_W     = PROD_W + 1 - RND_SHIFT;
    localparam int SUM_W     = SAMPLE_BITS + 3;

    localparam logic [CMD_W-1:0] CMD_HOLD         = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FAST_RELEASE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_IDLE         = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_RELEASE_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MASTER_VOLUME     = 3'd4;

    localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST    = 15'd32767;
    localparam logic [LEVEL_W-1:0] ATTACK_RST       = 15'd16;
    localparam logic [LEVEL_W-1:0] RELEASE_RST      = 15'd4;
    localparam logic [LEVEL_W-1:0] FAST_RELEASE_RST = 15'd64;
    localparam logic [VOL_W-1:0]   VOLUME_RST       = 16'd32768;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned SINE_FULL   = 64'd32767;

    typedef logic [SINE_W-1:0] sine_table_t [QUARTER_LEN];

    // taylor series in q30, terms through x^13, evaluated at elaboration
    function automatic logic [SINE_W-1:0] sine_entry(int unsigned i);
        longint unsigned a;
        longint unsigned t;
        longint unsigned v;
        longint          acc;
        a   = ((longint'(2 * i + 1)) * HALF_PI_Q30) >> (SINE_TABLE_BITS + 1);
        t   = a;
        acc = longint'(a);
        t   = (((t * a) >> 30) * a) >> 30;
        t   = t / 6;
        acc = acc - longint'(t);
        t   = (((t * a) >> 30) * a) >> 30;
        t   = t / 20;
        acc = acc + longint'(t);
        t   = (((t * a) >> 30) * a) >> 30;
        t   = t / 42;
        acc = acc - longint'(t);
        t   = (((t * a) >> 30) * a) >> 30;
        t   = t / 72;
        acc = acc + longint'(t);
        t   = (((t * a) >> 30) * a) >> 30;
        t   = t / 110;
        acc = acc - longint'(t);
        t   = (((t * a) >> 30) * a) >> 30;
        t   = t / 156;
        acc = acc + longint'(t);
        if (acc < 0)
        begin
            acc = 0;
        end
        v = (longint'(acc) * SINE_FULL + (64'd1 << 29)) >> 30;
        if (v > SINE_FULL)
        begin
            v = SINE_FULL;
        end
        return v[SINE_W-1:0];
    endfunction

    function automatic sine_table_t build_sine_table();
        sine_table_t tab;
        for (int i = 0; i < QUARTER_LEN; i++)
        begin
            tab[i] = sine_entry(i);
        end
        return tab;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

// ===== rtl/svle_if.sv =====
interface svle_in_if;
    import svle_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic                 note_start;
    logic [PHASE_W-1:0]   phase_step;
    logic signed [SAMPLE_BITS-1:0] mix_in;
    logic                 block_end;

    modport source (output valid, command, note_start, phase_step, mix_in, block_end,
                    input ready);
    modport sink   (input valid, command, note_start, phase_step, mix_in, block_end,
                    output ready);
endinterface

interface svle_out_if;
    import svle_pkg::*;

    logic                 valid;
    logic                 ready;
    logic signed [SAMPLE_BITS-1:0] mix_out;
    logic                 note_ended;
    logic [LEVEL_W-1:0]   envelope_level;
    logic                 block_end_out;

    modport source (output valid, mix_out, note_ended, envelope_level, block_end_out,
                    input ready);
    modport sink   (input valid, mix_out, note_ended, envelope_level, block_end_out,
                    output ready);
endinterface

// ===== rtl/sine_voice_with_linear_envelope.sv =====
// a request is accepted only in idle; the sequencer then steps through the rom, m2, m4, m5,
// ml, mv and sum states and waits in sum until the output register is free; five products
// go through one 30x16 multiplier after a registered quarter-wave rom read
// reset: phase, level and ended flag clear, registers take their default values,
// the block is ready for a request as soon as reset is released
module sine_voice_with_linear_envelope (
    input  logic                            clk,
    input  logic                            rst_n,
    svle_in_if.sink                         in_ch,
    svle_out_if.source                      out_ch,
    input  logic                            cfg_write,
    input  logic [svle_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [svle_pkg::CFG_W-1:0]      cfg_data
);
    import svle_pkg::*;

    `include "sine_voice_with_linear_envelope_assert.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROM  = 3'd1;
    localparam logic [2:0] S_M2   = 3'd2;
    localparam logic [2:0] S_M4   = 3'd3;
    localparam logic [2:0] S_M5   = 3'd4;
    localparam logic [2:0] S_ML   = 3'd5;
    localparam logic [2:0] S_MV   = 3'd6;
    localparam logic [2:0] S_SUM  = 3'd7;

    logic [2:0] state_reg, state_next;

    logic [LEVEL_W-1:0] max_level_reg;
    logic [LEVEL_W-1:0] attack_step_reg;
    logic [LEVEL_W-1:0] release_step_reg;
    logic [LEVEL_W-1:0] fast_release_step_reg;
    logic [VOL_W-1:0]   master_volume_reg;

    logic [PHASE_W-1:0] phase_accum_reg, phase_accum_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               ended_flag_reg, ended_flag_next;

    logic [CMD_W-1:0]              cmd_reg;
    logic signed [SAMPLE_BITS-1:0] mix_reg;
    logic                          blk_reg;
    logic                          ended_reg, ended_next;
    logic                          neg_reg;
    logic [SINE_TABLE_BITS-1:0]    addr_reg, addr_next;
    logic [SINE_W-1:0]             m_reg;
    logic [PROD_W-1:0]             prod_reg;

    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] mix_out_reg;
    logic                          note_ended_reg;
    logic [LEVEL_W-1:0]            level_out_reg;
    logic                          blk_out_reg;

    logic in_fire;
    logic out_load;

    // frame-start values after an optional note start
    logic [PHASE_W-1:0] phase_eff;
    logic [LEVEL_W-1:0] level_eff;
    logic               ended_eff;
    logic [LEVEL_W:0]   attack_sum;
    logic [LEVEL_W-1:0] dec_step;
    logic [1:0]         quad;

    logic [MUL_A_W:0]    rnd_sum;
    logic [SINE_W-1:0]   rnd_val;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;

    logic [PROD_W:0]              p_rnd;
    logic [MAG_W-1:0]             mag;
    logic signed [SUM_W-1:0]      voice;
    logic signed [SUM_W-1:0]      total;
    logic signed [SAMPLE_BITS-1:0] sat;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'd1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    assign in_fire      = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_load     = (state_reg == S_SUM) && (!out_valid_reg || out_ch.ready);

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.mix_out        = mix_out_reg;
    assign out_ch.note_ended     = note_ended_reg;
    assign out_ch.envelope_level = level_out_reg;
    assign out_ch.block_end_out  = blk_out_reg;

    // envelope and phase update at request accept
    always_comb
    begin
        phase_eff  = in_ch.note_start ? '0 : phase_accum_reg;
        level_eff  = in_ch.note_start ? '0 : level_reg;
        ended_eff  = in_ch.note_start ? 1'b0 : ended_flag_reg;
        attack_sum = {1'b0, level_eff} + {1'b0, attack_step_reg};
        dec_step   = (in_ch.command == CMD_RELEASE) ? release_step_reg : fast_release_step_reg;
        quad       = phase_eff[PHASE_W-1 -: 2];
        addr_next  = phase_eff[PHASE_W-3 -: SINE_TABLE_BITS];
        if (quad[0])
        begin
            addr_next = ~addr_next;
        end

        level_next       = level_eff;
        ended_next       = 1'b0;
        ended_flag_next  = ended_eff;
        phase_accum_next = phase_eff;
        case (in_ch.command)
            CMD_HOLD:
            begin
                if (level_eff < max_level_reg)
                begin
                    if (attack_sum > {1'b0, max_level_reg})
                    begin
                        level_next = max_level_reg;
                    end
                    else
                    begin
                        level_next = attack_sum[LEVEL_W-1:0];
                    end
                end
            end
            CMD_RELEASE, CMD_FAST_RELEASE:
            begin
                if (level_eff != '0)
                begin
                    level_next = (level_eff > dec_step) ? level_eff - dec_step : '0;
                end
                else if (!ended_eff)
                begin
                    ended_next      = 1'b1;
                    ended_flag_next = 1'b1;
                end
            end
            default:
            begin
                level_next = level_eff;
            end
        endcase
        if (in_ch.command != CMD_IDLE)
        begin
            phase_accum_next = phase_eff + in_ch.phase_step;
        end
        if (in_ch.block_end)
        begin
            ended_flag_next = 1'b0;
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        rnd_sum = {1'b0, prod_reg[MUL_A_W-1:0]} + (MUL_A_W + 1)'(1 << (SINE_W - 1));
        rnd_val = rnd_sum[MUL_A_W-1 -: SINE_W];
        mul_a   = '0;
        mul_b   = '0;
        unique case (state_reg)
            S_M2:
            begin
                mul_a = MUL_A_W'(m_reg);
                mul_b = MUL_B_W'(m_reg);
            end
            S_M4:
            begin
                mul_a = MUL_A_W'(rnd_val);
                mul_b = MUL_B_W'(rnd_val);
            end
            S_M5:
            begin
                mul_a = MUL_A_W'(rnd_val);
                mul_b = MUL_B_W'(m_reg);
            end
            S_ML:
            begin
                mul_a = MUL_A_W'(rnd_val);
                mul_b = MUL_B_W'(level_reg);
            end
            S_MV:
            begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = master_volume_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // final rounding, sign and saturating add
    always_comb
    begin
        p_rnd = {1'b0, prod_reg} + ((PROD_W + 1)'(1) << (RND_SHIFT - 1));
        mag   = p_rnd[PROD_W -: MAG_W];
        voice = neg_reg ? -$signed(SUM_W'(mag)) : $signed(SUM_W'(mag));
        if (cmd_reg == CMD_IDLE)
        begin
            voice = '0;
        end
        total = SUM_W'(mix_reg) + voice;
        if (total > SAT_HI)
        begin
            sat = SAT_HI[SAMPLE_BITS-1:0];
        end
        else if (total < SAT_LO)
        begin
            sat = SAT_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            sat = total[SAMPLE_BITS-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  state_next = in_fire ? S_ROM : S_IDLE;
            S_ROM:   state_next = S_M2;
            S_M2:    state_next = S_M4;
            S_M4:    state_next = S_M5;
            S_M5:    state_next = S_ML;
            S_ML:    state_next = S_MV;
            S_MV:    state_next = S_SUM;
            S_SUM:   state_next = out_load ? S_IDLE : S_SUM;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= S_IDLE;
            max_level_reg         <= MAX_LEVEL_RST;
            attack_step_reg       <= ATTACK_RST;
            release_step_reg      <= RELEASE_RST;
            fast_release_step_reg <= FAST_RELEASE_RST;
            master_volume_reg     <= VOLUME_RST;
            phase_accum_reg       <= '0;
            level_reg             <= '0;
            ended_flag_reg        <= 1'b0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_MAX_LEVEL:         max_level_reg         <= cfg_data[LEVEL_W-1:0];
                    REG_ATTACK_STEP:       attack_step_reg       <= cfg_data[LEVEL_W-1:0];
                    REG_RELEASE_STEP:      release_step_reg      <= cfg_data[LEVEL_W-1:0];
                    REG_FAST_RELEASE_STEP: fast_release_step_reg <= cfg_data[LEVEL_W-1:0];
                    REG_MASTER_VOLUME:     master_volume_reg     <= cfg_data[VOL_W-1:0];
                    default:               ;
                endcase
            end
            if (in_fire)
            begin
                phase_accum_reg <= phase_accum_next;
                level_reg       <= level_next;
                ended_flag_reg  <= ended_flag_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg   <= in_ch.command;
            mix_reg   <= in_ch.mix_in;
            blk_reg   <= in_ch.block_end;
            ended_reg <= ended_next;
            neg_reg   <= quad[1];
            addr_reg  <= addr_next;
        end
        if (state_reg == S_ROM)
        begin
            m_reg <= SINE_TABLE[addr_reg];
        end
        // the final product is held while the result waits for the output register
        if (state_reg != S_SUM)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (out_load)
        begin
            mix_out_reg    <= sat;
            note_ended_reg <= ended_reg;
            level_out_reg  <= level_reg;
            blk_out_reg    <= blk_reg;
        end
    end

    `SVLE_ASSERT_NEXT(a_accept_starts_seq, in_fire, state_reg == S_ROM)
    `SVLE_ASSERT_SAME(a_out_from_sum, $rose(out_valid_reg), $past(state_reg) == S_SUM)
    `SVLE_ASSERT_SAME(a_ended_at_zero, out_ch.valid && out_ch.note_ended,
                      out_ch.envelope_level == '0)

endmodule

// ===== bench/svle_voice_checker.sv =====
`timescale 1ns / 1ps

module svle_voice_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    svle_in_if                             in_ch,
    svle_out_if                            out_ch,
    input  logic                           cfg_write,
    input  logic [svle_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [svle_pkg::CFG_W-1:0]     cfg_data,
    output int                             fail_count,
    output int                             pending,
    output int                             frames_checked,
    output int                             endings_seen
);
    import svle_pkg::*;

    typedef longint unsigned u64_t;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] mix_out;
        logic                          note_ended;
        logic [LEVEL_W-1:0]            envelope_level;
        logic                          block_end_out;
    } voice_sample_t;

    localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    voice_sample_t      pending_samples [$];
    int unsigned        sine_rom [QUARTER_LEN];
    logic [PHASE_W-1:0] phase_acc;
    int unsigned        env_level;
    logic               ended_latch;
    int unsigned        ceiling;
    int unsigned        rise_step;
    int unsigned        fall_step;
    int unsigned        quick_fall_step;
    int unsigned        volume;

    // quarter-wave entry from a q30 taylor series, odd terms through x^13
    function automatic int unsigned quarter_sine(input int unsigned i);
        u64_t   a;
        u64_t   t;
        u64_t   v;
        longint acc;
        a   = (u64_t'(2 * i + 1) * HALF_PI_Q30) >> (SINE_TABLE_BITS + 1);
        t   = a;
        acc = longint'(a);
        for (int k = 1; k <= 6; k++)
        begin
            t = (t * a) >> 30;
            t = (t * a) >> 30;
            t = t / u64_t'(2 * k * (2 * k + 1));
            if (k % 2 == 1)
                acc = acc - longint'(t);
            else
                acc = acc + longint'(t);
        end
        if (acc < 0)
            acc = 0;
        v = (u64_t'(acc) * 32767 + (u64_t'(1) << 29)) >> 30;
        if (v > 32767)
            v = 32767;
        return v[31:0];
    endfunction

    initial
    begin
        for (int i = 0; i < QUARTER_LEN; i++)
            sine_rom[i] = quarter_sine(i);
    end

    // advances the voice by one frame and returns the sample it produces
    function automatic voice_sample_t render_frame(
        input logic [CMD_W-1:0]              cmd,
        input logic                          start,
        input logic [PHASE_W-1:0]            step,
        input logic signed [SAMPLE_BITS-1:0] mix,
        input logic                          blk
    );
        voice_sample_t r;
        logic [1:0]    quad;
        int unsigned   idx;
        int unsigned   dec;
        u64_t          m;
        u64_t          m2;
        u64_t          m4;
        u64_t          m5;
        u64_t          prod;
        u64_t          mag;
        longint        voice;
        longint        total;
        voice        = 0;
        r.note_ended = 1'b0;
        if (start)
        begin
            phase_acc   = '0;
            env_level   = 0;
            ended_latch = 1'b0;
        end
        if (cmd != CMD_IDLE)
        begin
            quad = phase_acc[PHASE_W-1 -: 2];
            idx  = phase_acc[PHASE_W-3 -: SINE_TABLE_BITS];
            if (cmd == CMD_HOLD)
            begin
                // rises only while below the ceiling, so a lowered ceiling holds the level
                if (env_level < ceiling)
                    env_level = (env_level + rise_step > ceiling) ? ceiling
                                                                  : env_level + rise_step;
            end
            else
            begin
                dec = (cmd == CMD_RELEASE) ? fall_step : quick_fall_step;
                if (env_level > 0)
                    env_level = (env_level > dec) ? env_level - dec : 0;
                else if (!ended_latch)
                begin
                    r.note_ended = 1'b1;
                    ended_latch  = 1'b1;
                end
            end
            if (quad[0])
                idx = QUARTER_LEN - 1 - idx;
            m     = sine_rom[idx];
            m2    = (m * m + 16384) >> 15;
            m4    = (m2 * m2 + 16384) >> 15;
            m5    = (m4 * m + 16384) >> 15;
            prod  = m5 * env_level * volume;
            mag   = (prod + (u64_t'(1) << (45 - SAMPLE_BITS))) >> (46 - SAMPLE_BITS);
            voice = quad[1] ? -longint'(mag) : longint'(mag);
            phase_acc = phase_acc + step;
        end
        total = longint'(mix) + voice;
        if (total > SAMPLE_MAX)
            total = SAMPLE_MAX;
        if (total < SAMPLE_MIN)
            total = SAMPLE_MIN;
        r.mix_out        = total[SAMPLE_BITS-1:0];
        r.envelope_level = env_level[LEVEL_W-1:0];
        r.block_end_out  = blk;
        if (blk)
            ended_latch = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        fail_count++;
        if (fail_count <= 40)
            $display("[%0t] frame %0d: %s is %0d, expected %0d",
                     $time, frames_checked, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        voice_sample_t want;
        if (!rst_n)
        begin
            pending_samples.delete();
            phase_acc       = '0;
            env_level       = 0;
            ended_latch     = 1'b0;
            ceiling         = MAX_LEVEL_RST;
            rise_step       = ATTACK_RST;
            fall_step       = RELEASE_RST;
            quick_fall_step = FAST_RELEASE_RST;
            volume          = VOLUME_RST;
            fail_count      = 0;
            pending         = 0;
            frames_checked  = 0;
            endings_seen    = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_MAX_LEVEL:         ceiling         = cfg_data[LEVEL_W-1:0];
                    REG_ATTACK_STEP:       rise_step       = cfg_data[LEVEL_W-1:0];
                    REG_RELEASE_STEP:      fall_step       = cfg_data[LEVEL_W-1:0];
                    REG_FAST_RELEASE_STEP: quick_fall_step = cfg_data[LEVEL_W-1:0];
                    REG_MASTER_VOLUME:     volume          = cfg_data[VOL_W-1:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_samples.size() == 0)
                    report_mismatch("result with nothing pending, mix_out", out_ch.mix_out, 0);
                else
                begin
                    want = pending_samples.pop_front();
                    frames_checked++;
                    endings_seen += want.note_ended;
                    if (out_ch.mix_out !== want.mix_out)
                        report_mismatch("mix_out", out_ch.mix_out, want.mix_out);
                    if (out_ch.note_ended !== want.note_ended)
                        report_mismatch("note_ended", out_ch.note_ended, want.note_ended);
                    if (out_ch.envelope_level !== want.envelope_level)
                        report_mismatch("envelope_level", out_ch.envelope_level,
                                        want.envelope_level);
                    if (out_ch.block_end_out !== want.block_end_out)
                        report_mismatch("block_end_out", out_ch.block_end_out,
                                        want.block_end_out);
                end
            end
            if (in_ch.valid && in_ch.ready)
                pending_samples.push_back(render_frame(in_ch.command, in_ch.note_start,
                                                       in_ch.phase_step, in_ch.mix_in,
                                                       in_ch.block_end));
            pending = pending_samples.size();
        end
    end

endmodule

// ===== bench/tb_sine_voice_with_linear_envelope.sv =====
`timescale 1ns / 1ps

module tb_sine_voice_with_linear_envelope;
    import svle_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 16;

    localparam logic signed [SAMPLE_BITS-1:0] MIX_TOP    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] MIX_BOTTOM = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 in_taken = 1'b0;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int fail_count;
    int pending;
    int frames_checked;
    int endings_seen;
    int send_idle_pct;
    int recv_idle_pct;
    int frames_sent;
    int settings_used;
    int stall_cycles = 0;

    svle_in_if  in_ch ();
    svle_out_if out_ch ();

    sine_voice_with_linear_envelope dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    svle_voice_checker voice_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .frames_checked (frames_checked),
        .endings_seen   (endings_seen)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
        out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    // in_taken tells the driver at the falling edge that its request went through
    always @(posedge clk)
    begin
        in_taken <= in_ch.valid && in_ch.ready;
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no request moved for %0d cycles", stall_cycles);
            $display("FAIL sine_voice_with_linear_envelope");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_frame(
        input logic [CMD_W-1:0]              cmd,
        input logic                          start,
        input logic [PHASE_W-1:0]            step,
        input logic signed [SAMPLE_BITS-1:0] mix,
        input logic                          blk
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.command    <= cmd;
        in_ch.note_start <= start;
        in_ch.phase_step <= step;
        in_ch.mix_in     <= mix;
        in_ch.block_end  <= blk;
        do
            @(negedge clk);
        while (!in_taken);
        frames_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
        @(negedge clk);
    endtask

    // registers change only once the voice has drained
    task automatic write_settings(input int unsigned top_level, input int unsigned rise,
                                  input int unsigned fall, input int unsigned quick_fall,
                                  input int unsigned gain);
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        write_reg(REG_MAX_LEVEL, top_level);
        write_reg(REG_ATTACK_STEP, rise);
        write_reg(REG_RELEASE_STEP, fall);
        write_reg(REG_FAST_RELEASE_STEP, quick_fall);
        write_reg(REG_MASTER_VOLUME, gain);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [PHASE_W-1:0] pick_step();
        case ($urandom_range(3))
            0:       return $urandom_range(0, 1 << 22);
            1:       return $urandom & 32'hFFF0_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_mix();
        int near;
        logic [31:0] raw;
        near = $urandom_range(0, 2000);
        near = near - 1000;
        raw  = $urandom;
        case ($urandom_range(9))
            0:       return MIX_TOP;
            1:       return MIX_BOTTOM;
            2, 3:    return near[SAMPLE_BITS-1:0];
            default: return raw[SAMPLE_BITS-1:0];
        endcase
    endfunction

    initial
    begin
        int                 n_hold;
        int                 n_rel;
        int                 stop_at;
        logic [CMD_W-1:0]   fall_cmd;
        logic [PHASE_W-1:0] step;
        in_ch.valid      = 1'b0;
        in_ch.command    = CMD_IDLE;
        in_ch.note_start = 1'b0;
        in_ch.phase_step = '0;
        in_ch.mix_in     = '0;
        in_ch.block_end  = 1'b0;
        out_ch.ready     = 1'b0;
        cfg_write        = 1'b0;
        cfg_index        = REG_MAX_LEVEL;
        cfg_data         = '0;
        send_idle_pct    = 33;
        recv_idle_pct    = 77;
        frames_sent      = 0;
        settings_used    = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset register values: idle passes the mix through, release at zero ends the note
        send_frame(CMD_IDLE, 1'b0, '1, MIX_TOP, 1'b0);
        send_frame(CMD_IDLE, 1'b0, '0, MIX_BOTTOM, 1'b0);
        send_frame(CMD_RELEASE, 1'b0, '0, '0, 1'b0);
        send_frame(CMD_FAST_RELEASE, 1'b0, '0, '0, 1'b1);
        // the next block reports its own note end
        send_frame(CMD_RELEASE, 1'b0, '0, '0, 1'b0);
        // quarter-turn steps visit all four quadrants
        send_frame(CMD_HOLD, 1'b1, 32'h4000_0000, '0, 1'b0);
        repeat (3) send_frame(CMD_HOLD, 1'b0, 32'h4000_0000, '0, 1'b0);

        // attack reaches the ceiling in a single step, gain above unity saturates both ways
        write_settings(32767, 32767, 32767, 1, 65535);
        send_frame(CMD_HOLD, 1'b1, 32'h4000_0000, MIX_TOP, 1'b0);
        send_frame(CMD_HOLD, 1'b0, 32'h4000_0000, MIX_TOP, 1'b0);
        send_frame(CMD_HOLD, 1'b0, 32'h4000_0000, '0, 1'b0);
        send_frame(CMD_HOLD, 1'b0, 32'h4000_0000, MIX_BOTTOM, 1'b0);

        // ceiling dropped below the level, then a release bigger than the level
        write_settings(100, 32767, 32767, 1, 32768);
        send_frame(CMD_HOLD, 1'b0, 32'h1234_5678, '0, 1'b0);
        send_frame(CMD_FAST_RELEASE, 1'b0, 32'h1234_5678, '0, 1'b0);
        send_frame(CMD_RELEASE, 1'b0, 32'h1234_5678, '0, 1'b0);
        send_frame(CMD_RELEASE, 1'b0, 32'h1234_5678, '0, 1'b0);
        // all-ones step wraps the phase every frame
        send_frame(CMD_HOLD, 1'b0, '1, MIX_BOTTOM, 1'b0);
        send_frame(CMD_HOLD, 1'b0, '1, MIX_TOP, 1'b1);

        write_settings(0, 0, 0, 0, 0);
        send_frame(CMD_HOLD, 1'b1, 32'h8000_0000, MIX_TOP, 1'b0);
        send_frame(CMD_RELEASE, 1'b0, 32'h8000_0000, '0, 1'b0);
        send_frame(CMD_FAST_RELEASE, 1'b0, 32'h8000_0000, '0, 1'b1);
        send_frame(CMD_IDLE, 1'b1, 32'h8000_0000, MIX_BOTTOM, 1'b0);

        for (int pace = 0; pace < 3; pace++)
        begin
            case (pace)
                0:
                begin
                    send_idle_pct = 33;
                    recv_idle_pct = 77;
                end
                1:
                begin
                    send_idle_pct = 77;
                    recv_idle_pct = 33;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 4; seg++)
            begin
                case (seg)
                    0: write_settings($urandom_range(0, 32767), $urandom_range(0, 32767),
                                      $urandom_range(0, 32767), $urandom_range(0, 32767),
                                      $urandom_range(0, 65535));
                    1: write_settings(32767, $urandom_range(1, 64), 1, 32767, 65535);
                    2: write_settings(MAX_LEVEL_RST, ATTACK_RST, RELEASE_RST,
                                      FAST_RELEASE_RST, VOLUME_RST);
                    default: write_settings($urandom_range(1000, 32767),
                                            $urandom_range(1, 2048), $urandom_range(1, 512),
                                            $urandom_range(256, 8192),
                                            $urandom_range(16384, 40000));
                endcase
                stop_at = frames_sent + 90;
                while (frames_sent < stop_at)
                begin
                    if ($urandom_range(99) < 15)
                    begin
                        // unrelated frames, stray note starts among them
                        repeat ($urandom_range(1, 8))
                            send_frame(CMD_W'($urandom_range(3)), $urandom_range(3) == 0,
                                       $urandom, pick_mix(), $urandom_range(7) == 0);
                    end
                    else
                    begin
                        step     = pick_step();
                        n_hold   = $urandom_range(1, 40);
                        n_rel    = $urandom_range(1, 40);
                        fall_cmd = ($urandom_range(9) < 7) ? CMD_RELEASE : CMD_FAST_RELEASE;
                        for (int i = 0; i < n_hold; i++)
                        begin
                            if ($urandom_range(9) == 0)
                                step = pick_step();
                            send_frame(($urandom_range(9) == 0) ? CMD_IDLE : CMD_HOLD, i == 0,
                                       step, pick_mix(), $urandom_range(7) == 0);
                        end
                        for (int i = 0; i < n_rel; i++)
                            send_frame(($urandom_range(9) == 0) ? CMD_IDLE : fall_cmd, 1'b0,
                                       step, pick_mix(), $urandom_range(7) == 0);
                    end
                end
            end
        end

        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("%0d frames checked across %0d register settings and three pacing mixes",
                 frames_checked, settings_used);
        $display("%0d note endings flagged along the way", endings_seen);
        if (fail_count == 0)
            $display("PASS sine_voice_with_linear_envelope");
        else
            $display("FAIL sine_voice_with_linear_envelope");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/svle_pkg.sv
rtl/svle_if.sv
rtl/sine_voice_with_linear_envelope.sv
bench/svle_voice_checker.sv
bench/tb_sine_voice_with_linear_envelope.sv
